// File: sv/url_path_split_percent_decode_core_macros.svh
// Assertion macros shared by the URL path splitter and percent decoder RTL.
// No dependencies; defining ASSERT_OFF compiles every check away.
`ifndef URL_PATH_SPLIT_PERCENT_DECODE_CORE_MACROS_SVH
`define URL_PATH_SPLIT_PERCENT_DECODE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Check on every rising edge of clk, ignored while rst_n is low.
`define UPSPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("url path decoder check failed");
// Check on every rising edge of clk, reset cycles included.
`define UPSPD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("url path decoder reset check failed");
`else
`define UPSPD_ASSERT(lbl, prop)
`define UPSPD_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: sv/upspd_pkg.sv
// Character codes and hex digit decoding for the URL path splitter.
// No dependencies.
`timescale 1ns / 1ps

package upspd_pkg;

  localparam logic [7:0] CH_HASH    = 8'h23;  // '#'
  localparam logic [7:0] CH_QUEST   = 8'h3F;  // '?'
  localparam logic [7:0] CH_PERCENT = 8'h25;  // '%'
  localparam logic [7:0] CH_PLUS    = 8'h2B;  // '+'
  localparam logic [7:0] CH_SPACE   = 8'h20;  // ' '
  localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE    = 8'h39;  // '9'
  localparam logic [7:0] CH_LA      = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF      = 8'h66;  // 'f'
  localparam logic [7:0] CH_UA      = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF      = 8'h46;  // 'F'
  localparam logic [7:0] HEX_TEN    = 8'd10;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Decodes one ASCII hex digit; ok is low for any other byte.
  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t       h;
    logic [7:0] t;
    h.ok  = 1'b0;
    h.val = 4'd0;
    t     = 8'd0;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      t = b - CH_ZERO;
      h.ok = 1'b1;
    end else if (b >= CH_LA && b <= CH_LF) begin
      t = b - CH_LA + HEX_TEN;
      h.ok = 1'b1;
    end else if (b >= CH_UA && b <= CH_UF) begin
      t = b - CH_UA + HEX_TEN;
      h.ok = 1'b1;
    end
    h.val = t[3:0];
    return h;
  endfunction

endpackage

// File: sv/url_path_split_percent_decode_core.sv
// Top level of the URL path splitter and percent decoder.
// Depends on upspd_pkg and url_path_split_percent_decode_core_macros.svh.
`timescale 1ns / 1ps
`include "url_path_split_percent_decode_core_macros.svh"

// How to use this block:
// Feed one byte of a request target per request on the in_ channel, with
// in_last high on the final byte. Every input request yields exactly one
// request on the out_ channel. In the path part (before the first '?'),
// '+' becomes a space and a '%' escape with two hex digits becomes one byte;
// query bytes pass raw with out_part high; from the first '#' on, nothing is
// produced (out_has_byte low). A malformed or cut-short escape raises
// out_bad_escape once, and the rest of that target is swallowed.
// out_target_done marks the result of the byte that carried in_last.
// The result is registered twice before it can be taken: once in the input
// register, once in the result register. Throughput is one byte per cycle
// while out_stall does not hold the result register; the only loop is the
// region state update, a few gate levels between the two registers.
// When out_stall is high the result register holds; the input register
// still takes one more request, after which in_stall rises in the same
// cycle as out_stall. Reset (synchronous rst_n low) empties both registers
// and returns the decoder to the start of a path.
module url_path_split_percent_decode_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_part,
  output logic       out_bad_escape,
  output logic       out_target_done
);

  typedef enum logic [2:0] {
    MODE_PATH   = 3'd0,
    MODE_ESC_HI = 3'd1,
    MODE_ESC_LO = 3'd2,
    MODE_QUERY  = 3'd3,
    MODE_DROP   = 3'd4,
    MODE_ERR    = 3'd5
  } mode_t;

  // Input register.
  logic       st_valid_r;
  logic [7:0] st_byte_r;
  logic       st_last_r;

  // Decoder state.
  mode_t      mode_r, mode_nxt;
  logic [3:0] nib_r, nib_nxt;

  // Result register.
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_has_r;
  logic       out_part_r;
  logic       out_bad_r;
  logic       out_done_r;

  // Combinational result for the byte in the input register.
  logic [7:0] ob_nxt;
  logic       has_nxt;
  logic       part_nxt;
  logic       bad_nxt;

  upspd_pkg::hex_t hex;

  logic out_adv;  // result register free to load
  logic st_move;  // input register hands its byte on this cycle
  logic in_take;

  assign out_adv  = !out_valid_r || !out_stall;
  assign st_move  = st_valid_r && out_adv;
  assign in_stall = st_valid_r && !out_adv;
  assign in_take  = in_valid && !in_stall;

  assign hex = upspd_pkg::hex_digit(st_byte_r);

  always_comb begin
    mode_nxt = mode_r;
    nib_nxt  = nib_r;
    ob_nxt   = 8'd0;
    has_nxt  = 1'b0;
    part_nxt = 1'b0;
    bad_nxt  = 1'b0;
    unique case (mode_r)
      MODE_PATH: begin
        if (st_byte_r == upspd_pkg::CH_HASH) begin
          mode_nxt = MODE_DROP;
        end else if (st_byte_r == upspd_pkg::CH_QUEST) begin
          mode_nxt = MODE_QUERY;
        end else if (st_byte_r == upspd_pkg::CH_PERCENT) begin
          mode_nxt = MODE_ESC_HI;
        end else if (st_byte_r == upspd_pkg::CH_PLUS) begin
          ob_nxt  = upspd_pkg::CH_SPACE;
          has_nxt = 1'b1;
        end else begin
          ob_nxt  = st_byte_r;
          has_nxt = 1'b1;
        end
      end
      MODE_ESC_HI: begin
        if (hex.ok) begin
          nib_nxt  = hex.val;
          mode_nxt = MODE_ESC_LO;
        end else begin
          bad_nxt  = 1'b1;
          mode_nxt = MODE_ERR;
        end
      end
      MODE_ESC_LO: begin
        if (hex.ok) begin
          ob_nxt   = {nib_r, hex.val};
          has_nxt  = 1'b1;
          mode_nxt = MODE_PATH;
        end else begin
          bad_nxt  = 1'b1;
          mode_nxt = MODE_ERR;
        end
      end
      MODE_QUERY: begin
        if (st_byte_r == upspd_pkg::CH_HASH) begin
          mode_nxt = MODE_DROP;
        end else begin
          ob_nxt   = st_byte_r;
          has_nxt  = 1'b1;
          part_nxt = 1'b1;
        end
      end
      MODE_DROP: begin
        mode_nxt = MODE_DROP;
      end
      default: begin
        // Error mode and any unused code discard the byte.
        mode_nxt = MODE_ERR;
      end
    endcase

    // The end of a target closes any open escape as an error and rearms
    // the decoder for the next path.
    if (st_last_r) begin
      if (mode_nxt == MODE_ESC_HI || mode_nxt == MODE_ESC_LO) begin
        bad_nxt = 1'b1;
      end
      mode_nxt = MODE_PATH;
      nib_nxt  = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_PATH;
      nib_r       <= 4'd0;
    end else begin
      if (in_take) begin
        st_valid_r <= 1'b1;
      end else if (st_move) begin
        st_valid_r <= 1'b0;
      end
      if (out_adv) begin
        out_valid_r <= st_valid_r;
      end
      if (st_move) begin
        mode_r <= mode_nxt;
        nib_r  <= nib_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      st_byte_r <= in_byte;
      st_last_r <= in_last;
    end
    if (st_move) begin
      out_byte_r <= ob_nxt;
      out_has_r  <= has_nxt;
      out_part_r <= part_nxt;
      out_bad_r  <= bad_nxt;
      out_done_r <= st_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_has_byte    = out_has_r;
  assign out_part        = out_part_r;
  assign out_bad_escape  = out_bad_r;
  assign out_target_done = out_done_r;

  // A query flag only ever travels with a produced byte.
  `UPSPD_ASSERT(a_part_has_byte, out_valid_r && out_part_r |-> out_has_r)
  // An error report never comes with a produced byte.
  `UPSPD_ASSERT(a_bad_no_byte, out_valid_r && out_bad_r |-> !out_has_r)
  // After the last byte of a target moves on, decoding restarts in the path.
  `UPSPD_ASSERT(a_last_rearms, st_move && st_last_r |=> mode_r == MODE_PATH && nib_r == 4'd0)
  // The input side only holds off while the input register is occupied.
  `UPSPD_ASSERT(a_stall_only_full, in_stall |-> st_valid_r)
  // Reset leaves both registers empty.
  `UPSPD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !st_valid_r && !out_valid_r)

endmodule

// File: verif/url_decode_check.sv
// Checker for the URL path splitter and percent decoder: watches both channels,
// predicts each result from the accepted request bytes and compares field by field.
// Depends on upspd_pkg for the character codes.
`timescale 1ns / 1ps

module url_decode_check (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_has_byte,
  input  logic       out_part,
  input  logic       out_bad_escape,
  input  logic       out_target_done,
  output int         mismatches,
  output int         results_left,
  output int         results_seen,
  output int         escapes_flagged,
  output int         query_bytes
);

  typedef enum logic [2:0] {
    ST_PATH,
    ST_ESC_HI,
    ST_ESC_LO,
    ST_QUERY,
    ST_DROP,
    ST_ERR
  } region_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       part;
    logic       bad;
    logic       done;
  } result_t;

  region_t    region;
  logic [3:0] hi_nib;
  result_t    decoded_fifo[$];

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [7:0] t;
    t = 8'd0;
    if (b >= upspd_pkg::CH_ZERO && b <= upspd_pkg::CH_NINE) begin
      t = b - upspd_pkg::CH_ZERO;
      return {1'b1, t[3:0]};
    end
    if (b >= upspd_pkg::CH_LA && b <= upspd_pkg::CH_LF) begin
      t = b - upspd_pkg::CH_LA + upspd_pkg::HEX_TEN;
      return {1'b1, t[3:0]};
    end
    if (b >= upspd_pkg::CH_UA && b <= upspd_pkg::CH_UF) begin
      t = b - upspd_pkg::CH_UA + upspd_pkg::HEX_TEN;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

  // Advances the region state by one byte and returns the result it gives.
  function automatic result_t decode_byte(input logic [7:0] b, input logic last);
    result_t    r;
    logic [4:0] h;
    r = '0;
    h = hex_nibble(b);
    case (region)
      ST_PATH: begin
        if (b == upspd_pkg::CH_HASH) begin
          region = ST_DROP;
        end else if (b == upspd_pkg::CH_QUEST) begin
          region = ST_QUERY;
        end else if (b == upspd_pkg::CH_PERCENT) begin
          region = ST_ESC_HI;
        end else begin
          r.has  = 1'b1;
          r.data = (b == upspd_pkg::CH_PLUS) ? upspd_pkg::CH_SPACE : b;
        end
      end
      ST_ESC_HI: begin
        if (h[4]) begin
          hi_nib = h[3:0];
          region = ST_ESC_LO;
        end else begin
          r.bad  = 1'b1;
          region = ST_ERR;
        end
      end
      ST_ESC_LO: begin
        if (h[4]) begin
          r.has  = 1'b1;
          r.data = {hi_nib, h[3:0]};
          region = ST_PATH;
        end else begin
          r.bad  = 1'b1;
          region = ST_ERR;
        end
      end
      ST_QUERY: begin
        if (b == upspd_pkg::CH_HASH) begin
          region = ST_DROP;
        end else begin
          r.has  = 1'b1;
          r.part = 1'b1;
          r.data = b;
        end
      end
      ST_DROP: ;
      default: region = ST_ERR;
    endcase
    if (last) begin
      if (region == ST_ESC_HI || region == ST_ESC_LO) r.bad = 1'b1;
      region = ST_PATH;
      hi_nib = 4'd0;
    end
    r.done = last;
    return r;
  endfunction

  task automatic flag_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      region = ST_PATH;
      hi_nib = 4'd0;
      decoded_fifo.delete();
    end else begin
      if (in_valid && !in_stall) decoded_fifo.push_back(decode_byte(in_byte, in_last));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (decoded_fifo.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request outstanding, expected none, got byte %h",
                   $time, out_byte);
        end else begin
          want = decoded_fifo.pop_front();
          flag_field("out_byte", want.data, out_byte);
          flag_field("out_has_byte", {7'd0, want.has}, {7'd0, out_has_byte});
          flag_field("out_part", {7'd0, want.part}, {7'd0, out_part});
          flag_field("out_bad_escape", {7'd0, want.bad}, {7'd0, out_bad_escape});
          flag_field("out_target_done", {7'd0, want.done}, {7'd0, out_target_done});
          if (want.bad) escapes_flagged++;
          if (want.part) query_bytes++;
        end
      end
    end
    results_left = decoded_fifo.size();
  end

endmodule

// File: verif/tb.sv
// Testbench top for url_path_split_percent_decode_core: drives request targets,
// applies back-pressure and gives the verdict.
// Depends on upspd_pkg, the core RTL and url_decode_check.
`timescale 1ns / 1ps

module tb;

  // Every input of the block holds a known value from time zero.
  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_stall = 1'b0;

  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_has_byte;
  logic       out_part;
  logic       out_bad_escape;
  logic       out_target_done;

  int mismatches;
  int results_left;
  int results_seen;
  int escapes_flagged;
  int query_bytes;

  // While quiet is set neither side idles, so the block runs at full rate.
  logic quiet = 1'b0;
  // The stimulus asks for a long receiver hold-off by bumping hold_asks; the
  // receiver process serves each ask once and counts the hold in cycles.
  int   hold_asks   = 0;
  int   hold_served = 0;
  int   hold_cnt    = 0;
  int   requests    = 0;

  logic [7:0] target_bytes[$];

  always #10 clk = ~clk;

  url_path_split_percent_decode_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_has_byte    (out_has_byte),
    .out_part        (out_part),
    .out_bad_escape  (out_bad_escape),
    .out_target_done (out_target_done)
  );

  url_decode_check u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_has_byte    (out_has_byte),
    .out_part        (out_part),
    .out_bad_escape  (out_bad_escape),
    .out_target_done (out_target_done),
    .mismatches      (mismatches),
    .results_left    (results_left),
    .results_seen    (results_seen),
    .escapes_flagged (escapes_flagged),
    .query_bytes     (query_bytes)
  );

  // Receiver. A long hold-off keeps out_stall high so that both internal
  // registers fill and in_stall rises while the sender keeps offering.
  // Otherwise the receiver stalls at random with a 19 percent chance,
  // except during the quiet stretch.
  always @(posedge clk) begin
    if (hold_served != hold_asks) begin
      hold_served <= hold_served + 1;
      hold_cnt    <= 60;
      out_stall   <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 19);
    end
  end

  // Hard limit on the run. The slowest correct run is far below this.
  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

  // Offers one request and waits until it is accepted. The payload stays put
  // while stalled. After acceptance the sender sometimes drops valid before
  // the next request; when it does not, the next call keeps valid high with a
  // single assignment in that time step.
  task automatic send_req(input logic [7:0] b, input logic last);
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests++;
    if (!quiet && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < 19) @(posedge clk);
    end
  endtask

  // Sends a text string as bytes; last marks the final byte if requested.
  task automatic send_text(input string s, input logic ends_target);
    for (int i = 0; i < s.len(); i++) begin
      send_req(s[i], ends_target && (i == s.len() - 1));
    end
  endtask

  // A hex digit of the given value, in upper or lower case at random.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return upspd_pkg::CH_ZERO + v;
    if ($urandom_range(0, 1)) return upspd_pkg::CH_UA + v - upspd_pkg::HEX_TEN;
    return upspd_pkg::CH_LA + v - upspd_pkg::HEX_TEN;
  endfunction

  // Any byte except '#', '?' and '%' ('+' included).
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == upspd_pkg::CH_HASH || b == upspd_pkg::CH_QUEST ||
           b == upspd_pkg::CH_PERCENT) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Builds one request target into target_bytes. Most targets are well formed:
  // a path of plain bytes, plus signs and valid escapes, an optional query
  // and an optional fragment. The rest are noise heavy in percent signs,
  // hex digits, '?' and '#', which yields bad and cut-short escapes.
  task automatic make_target();
    logic [7:0] b;
    target_bytes.delete();
    if ($urandom_range(0, 99) < 80) begin
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            target_bytes.push_back(upspd_pkg::CH_PERCENT);
            target_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
            target_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
          end
          2: target_bytes.push_back(upspd_pkg::CH_PLUS);
          default: target_bytes.push_back(plain_byte());
        endcase
      end
      if ($urandom_range(0, 99) < 60) begin
        target_bytes.push_back(upspd_pkg::CH_QUEST);
        repeat ($urandom_range(0, 8)) begin
          b = 8'($urandom_range(0, 255));
          target_bytes.push_back(b == upspd_pkg::CH_HASH ? upspd_pkg::CH_QUEST : b);
        end
      end
      // The fragment tail is kept short since the block just swallows it.
      if ($urandom_range(0, 99) < 20) begin
        target_bytes.push_back(upspd_pkg::CH_HASH);
        repeat ($urandom_range(0, 3)) target_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if (target_bytes.size() == 0) target_bytes.push_back(plain_byte());
    end else begin
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(0, 9))
          0, 1, 2: target_bytes.push_back(upspd_pkg::CH_PERCENT);
          3: target_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
          4: target_bytes.push_back(upspd_pkg::CH_QUEST);
          5: target_bytes.push_back(upspd_pkg::CH_HASH);
          default: target_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed targets. The first covers the byte extremes, '+' to space,
    // escapes using '0', 'a', 'A' and 'F', a query passing '%' through raw,
    // and a '#' inside the query that drops the rest.
    send_req(8'h00, 1'b0);
    send_text("+%0a%FA?", 1'b0);
    send_req(8'hFF, 1'b0);
    send_text("%#q", 1'b1);
    // A '#' in the path drops everything after it.
    send_text("#x", 1'b1);
    // A '?' where an escape digit is due is a bad escape, reported once even
    // though the same byte also ends the target.
    send_text("%?", 1'b1);
    // Bytes already out stay out; after the bad digit the rest is discarded.
    send_text("a%gb", 1'b1);
    // Escapes cut short by the end of the target, after one digit and after
    // the percent sign alone.
    send_text("%4", 1'b1);
    send_text("%", 1'b1);
    // A '#' where an escape digit is due.
    send_text("%#", 1'b1);

    // Random targets, with a no-idle stretch in the middle and two long
    // receiver hold-offs while requests keep coming.
    while (requests < 2000) begin
      quiet <= (requests >= 700 && requests < 1000);
      if (hold_asks == 0 && requests >= 300) hold_asks <= 1;
      if (hold_asks == 1 && requests >= 1500) hold_asks <= 2;
      make_target();
      for (int i = 0; i < target_bytes.size(); i++) begin
        send_req(target_bytes[i], i == target_bytes.size() - 1);
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every outstanding result, then keep the clock running so a
    // stray extra result would still be caught.
    @(posedge clk);
    while (results_left != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Run covered %0d requests and %0d checked results, %0d of them query bytes",
             requests, results_seen, query_bytes);
    $display("and %0d bad escape reports, with two long receiver hold-offs.", escapes_flagged);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/upspd_pkg.sv
sv/url_path_split_percent_decode_core.sv
verif/url_decode_check.sv
verif/tb.sv
